@@ rtl/rbcc_pkg.sv @@
package rbcc_pkg;

   localparam int unsigned WORD_W  = 15;
   localparam int unsigned IMAGE_W = 16;
   localparam int unsigned COUNT_W = 16;

   // ones'-complement folding: a sum beyond +/-FOLD_LIMIT wraps by FOLD_LIMIT+1
   // with the carry added back at the other end
   localparam logic signed [15:0] FOLD_LIMIT = 16'sd16383;

   localparam logic [WORD_W-1:0]  WORD_ONES = 15'h7FFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [COUNT_W-1:0] EXPECTED_WORDS_RESET = 16'd36864;

   typedef enum logic [1:0] {
      MODE_DATA   = 2'd0,
      MODE_CHECK  = 2'd1,
      MODE_MARKER = 2'd2,
      MODE_END    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CHK_NONE     = 2'd0,
      CHK_POS      = 2'd1,
      CHK_NEG      = 2'd2,
      CHK_MISMATCH = 2'd3
   } check_type;

endpackage

@@ rtl/rbcc_req_if.sv @@
interface rbcc_req_if
   import rbcc_pkg::*;
();
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [WORD_W-1:0]   value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

@@ rtl/rbcc_rsp_if.sv @@
interface rbcc_rsp_if
   import rbcc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                has_word;
   logic [IMAGE_W-1:0]  image_word;
   check_type           check_result;
   logic                alignment_error;
   logic                length_error;
   logic [WORD_W-1:0]   running_sum;
   logic [COUNT_W-1:0]  errors_so_far;

   modport source (
      output valid, output has_word, output image_word, output check_result,
      output alignment_error, output length_error, output running_sum,
      output errors_so_far, input ready
   );
   modport sink (
      input valid, input has_word, input image_word, input check_result,
      input alignment_error, input length_error, input running_sum,
      input errors_so_far, output ready
   );
endinterface

@@ rtl/rope_bank_checksum_checker_core.sv @@
// Rope bank checksum checker. Takes a stream of tagged 15-bit items (data
// word, bank check word, bank marker, end of image) and returns exactly one
// result per item: the image word to append (data shifted left one bit,
// check words as given), the bank check outcome, alignment and length flags,
// the running 15-bit ones'-complement sum (end-around carry, never negative
// zero) and a saturating error count. A transfer on req_bus is registered in
// the input register, worked in short logic (one 15-bit end-around add and
// a few compares) and written to the result register that drives rsp_bus;
// rsp valid rises once the item reaches the result register. The block
// sustains one item per cycle; rsp_bus back-pressure stalls req_bus only
// once both registers are full. csr_wr_data sets the expected image length
// (reset 36864 words); write it only while no item is in flight. Banks are
// BANK_WORDS words long; word_count saturates at 65535.
module rope_bank_checksum_checker_core
   import rbcc_pkg::*;
#(
   parameter int unsigned BANK_WORDS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   rbcc_req_if.sink            req_bus,
   rbcc_rsp_if.source          rsp_bus,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int unsigned BANK_OFS_W = $clog2(BANK_WORDS);
   localparam logic [BANK_OFS_W-1:0] BANK_LAST = BANK_OFS_W'(BANK_WORDS - 1);

   // input register
   logic                s1_valid_ff;
   mode_type            s1_mode_ff;
   logic [WORD_W-1:0]   s1_value_ff;

   // result register
   logic                out_valid_ff;
   logic                out_has_word_ff;
   logic [IMAGE_W-1:0]  out_image_word_ff;
   check_type           out_check_ff;
   logic                out_align_ff;
   logic                out_length_ff;
   logic [WORD_W-1:0]   out_sum_ff;
   logic [COUNT_W-1:0]  out_errors_ff;

   // checker state
   logic [COUNT_W-1:0]    expected_ff;
   logic [WORD_W-1:0]     sum_ff;
   logic [WORD_W-1:0]     bank_ff;
   logic                  check_pend_ff;
   logic [COUNT_W-1:0]    word_count_ff;
   logic [BANK_OFS_W-1:0] bank_ofs_ff;
   logic [COUNT_W-1:0]    tally_ff;

   // next values
   logic                  has_word_in;
   logic [IMAGE_W-1:0]    image_word_in;
   check_type             check_in;
   logic                  align_in;
   logic                  length_in;
   logic [WORD_W-1:0]     sum_in;
   logic                  check_pend_in;
   logic [COUNT_W-1:0]    word_count_in;
   logic [BANK_OFS_W-1:0] bank_ofs_in;
   logic [COUNT_W-1:0]    tally_in;

   logic                  s1_move;
   logic [WORD_W-1:0]     add_sum;
   logic [WORD_W-1:0]     cmp_sum;
   logic                  settle;
   logic                  mismatch;
   logic [1:0]            err_inc;
   logic [COUNT_W:0]      tally_wide;

   // advance the input register into the result register when the result
   // register is empty or being drained this cycle
   assign s1_move       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;

   rbcc_oc_add u_oc_add (
      .a   (sum_ff),
      .b   (s1_value_ff),
      .sum (add_sum)
   );

   // a check word settles against the sum including itself; marker and end
   // mark settle against the old sum
   assign cmp_sum = (s1_mode_ff == MODE_CHECK) ? add_sum : sum_ff;
   assign settle  = check_pend_ff && (s1_mode_ff != MODE_DATA);

   always_comb begin
      check_in = CHK_NONE;
      mismatch = 1'b0;
      if (settle) begin
         priority if (cmp_sum == bank_ff) begin
            check_in = CHK_POS;
         end else if (cmp_sum == (WORD_ONES & ~bank_ff)) begin
            check_in = CHK_NEG;
         end else begin
            check_in = CHK_MISMATCH;
            mismatch = 1'b1;
         end
      end
   end

   always_comb begin
      has_word_in   = 1'b0;
      image_word_in = '0;
      align_in      = 1'b0;
      length_in     = 1'b0;
      sum_in        = sum_ff;
      check_pend_in = check_pend_ff && !settle;
      word_count_in = word_count_ff;
      bank_ofs_in   = bank_ofs_ff;
      unique case (s1_mode_ff)
         MODE_DATA, MODE_CHECK: begin
            has_word_in   = 1'b1;
            image_word_in = (s1_mode_ff == MODE_DATA) ? {s1_value_ff, 1'b0}
                                                      : {1'b0, s1_value_ff};
            sum_in        = add_sum;
            // hold the count at its maximum; the bank offset stops with it
            if (word_count_ff != COUNT_MAX) begin
               word_count_in = word_count_ff + 1'b1;
               bank_ofs_in   = (bank_ofs_ff == BANK_LAST) ? '0
                                                          : bank_ofs_ff + 1'b1;
            end
         end
         MODE_MARKER: begin
            sum_in        = '0;
            align_in      = (bank_ofs_ff != '0);
            check_pend_in = 1'b1;
         end
         MODE_END: begin
            length_in = (word_count_ff != expected_ff);
         end
         default: begin
         end
      endcase
   end

   // a marker or end mark can add a mismatch and its own error in one item
   assign err_inc    = {1'b0, mismatch} + {1'b0, align_in || length_in};
   assign tally_wide = {1'b0, tally_ff} + {{(COUNT_W-1){1'b0}}, err_inc};
   assign tally_in   = tally_wide[COUNT_W] ? COUNT_MAX : tally_wide[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         expected_ff   <= EXPECTED_WORDS_RESET;
         sum_ff        <= '0;
         check_pend_ff <= 1'b0;
         word_count_ff <= '0;
         bank_ofs_ff   <= '0;
         tally_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            expected_ff <= csr_wr_data;
         end
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s1_move) begin
            out_valid_ff  <= 1'b1;
            sum_ff        <= sum_in;
            check_pend_ff <= check_pend_in;
            word_count_ff <= word_count_in;
            bank_ofs_ff   <= bank_ofs_in;
            tally_ff      <= tally_in;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_mode_ff  <= req_bus.mode;
         s1_value_ff <= req_bus.value;
      end
      if (s1_move) begin
         if (s1_mode_ff == MODE_MARKER) begin
            bank_ff <= s1_value_ff;
         end
         out_has_word_ff   <= has_word_in;
         out_image_word_ff <= image_word_in;
         out_check_ff      <= check_in;
         out_align_ff      <= align_in;
         out_length_ff     <= length_in;
         out_sum_ff        <= sum_in;
         out_errors_ff     <= tally_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.has_word        = out_has_word_ff;
   assign rsp_bus.image_word      = out_image_word_ff;
   assign rsp_bus.check_result    = out_check_ff;
   assign rsp_bus.alignment_error = out_align_ff;
   assign rsp_bus.length_error    = out_length_ff;
   assign rsp_bus.running_sum     = out_sum_ff;
   assign rsp_bus.errors_so_far   = out_errors_ff;

endmodule

@@ rtl/rbcc_oc_add.sv @@
module rbcc_oc_add
   import rbcc_pkg::*;
(
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   output logic [WORD_W-1:0] sum
);

   logic signed [15:0] a_int;
   logic signed [15:0] b_int;
   logic signed [15:0] raw;
   logic signed [15:0] folded;
   logic signed [15:0] mag;

   // negative operands: magnitude is the inverted low 14 bits
   assign a_int = a[WORD_W-1] ? -$signed({2'b00, ~a[WORD_W-2:0]})
                              :  $signed({2'b00,  a[WORD_W-2:0]});
   assign b_int = b[WORD_W-1] ? -$signed({2'b00, ~b[WORD_W-2:0]})
                              :  $signed({2'b00,  b[WORD_W-2:0]});
   assign raw = a_int + b_int;

   always_comb begin
      priority if (raw > FOLD_LIMIT) begin
         folded = raw - FOLD_LIMIT;
      end else if (raw < -FOLD_LIMIT) begin
         folded = raw + FOLD_LIMIT;
      end else begin
         folded = raw;
      end
   end

   // zero always encodes as +0
   assign mag = -folded;
   assign sum = folded[15] ? (WORD_ONES & ~mag[WORD_W-1:0]) : folded[WORD_W-1:0];

endmodule
